@@ design/assert_macros.svh @@
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TSD_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/tsd_pkg.sv @@
// types and codes shared by the tlv stream deframer
package tsd_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_TYPE,
		PH_ID,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_HEADER  = 2'd1;
	localparam logic [1:0] ERR_PAYLOAD = 2'd2;

	localparam int unsigned ID_W  = 16;
	localparam int unsigned LEN_W = 24;

	// one result item
	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       etype;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [7:0]       pbyte;
		logic             last;
		logic [1:0]       err;
		logic             done;
	} result_t;

endpackage

@@ design/tsd_in_reg.sv @@
// input register stage holding one received byte
module tsd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_eom,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       eom_s1
);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the request
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_s1 <= in_byte;
			eom_s1  <= in_eom;
		end
	end

endmodule

@@ design/tsd_core.sv @@
// tlv header and payload parser: state registers and one-byte decode
`include "assert_macros.svh"

module tsd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic             eom,
	output logic             res_valid,
	output tsd_pkg::result_t res
);

	tsd_pkg::phase_t                phase_q, phase_n;
	logic [7:0]                     saved_q, saved_n;
	logic [tsd_pkg::ID_W-1:0]       id_q, id_n;
	logic [tsd_pkg::LEN_W-1:0]      len_q, len_n;
	logic [1:0]                     fbl_q, fbl_n;
	logic [tsd_pkg::LEN_W-1:0]      pbl_q, pbl_n;

	// shared decode
	logic [1:0]                     fbl_dec;
	logic [1:0]                     len_form;
	logic [tsd_pkg::ID_W-1:0]       id_shift;
	logic [tsd_pkg::LEN_W-1:0]      hdr_len;
	logic [tsd_pkg::LEN_W-1:0]      pbl_dec;
	logic                           field_more;
	logic                           hdr_complete;
	logic                           leaf_nz;
	logic                           pay_more;
	logic                           err_hdr;
	logic                           err_pay;
	logic                           fail;

	always_comb begin
		fbl_dec    = fbl_q - 2'd1;
		len_form   = saved_q[4:3];
		id_shift   = {id_q[7:0], in_byte};
		hdr_len    = (phase_q == tsd_pkg::PH_LEN) ? {len_q[15:0], in_byte}
			: {21'd0, saved_q[2:0]};
		pbl_dec    = pbl_q - 24'd1;
		field_more = (fbl_dec != 2'd0);
		hdr_complete = ((phase_q == tsd_pkg::PH_ID) && !field_more && (len_form == 2'd0))
			|| ((phase_q == tsd_pkg::PH_LEN) && !field_more);
		// types 1 and 3 carry their payload inline
		leaf_nz    = saved_q[6] && (hdr_len != '0);
		pay_more   = (phase_q == tsd_pkg::PH_PAYLOAD) && (pbl_dec != '0);
		err_hdr    = eom && ((phase_q == tsd_pkg::PH_TYPE)
			|| ((phase_q == tsd_pkg::PH_ID) && (field_more || (len_form != 2'd0)))
			|| ((phase_q == tsd_pkg::PH_LEN) && field_more));
		err_pay    = eom && ((hdr_complete && leaf_nz) || pay_more);
		fail       = err_hdr || err_pay;
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		saved_n = saved_q;
		id_n    = id_q;
		len_n   = len_q;
		fbl_n   = fbl_q;
		pbl_n   = pbl_q;
		unique case (phase_q)
			tsd_pkg::PH_TYPE: begin
				phase_n = tsd_pkg::PH_ID;
				saved_n = in_byte;
				id_n    = '0;
				len_n   = '0;
				pbl_n   = '0;
				fbl_n   = in_byte[5] ? 2'd2 : 2'd1;
			end
			tsd_pkg::PH_ID: begin
				id_n = id_shift;
				if (field_more) begin
					fbl_n = fbl_dec;
				end else if (len_form != 2'd0) begin
					fbl_n   = len_form;
					phase_n = tsd_pkg::PH_LEN;
				end else begin
					fbl_n   = 2'd0;
					len_n   = hdr_len;
					pbl_n   = leaf_nz ? hdr_len : '0;
					phase_n = leaf_nz ? tsd_pkg::PH_PAYLOAD : tsd_pkg::PH_TYPE;
				end
			end
			tsd_pkg::PH_LEN: begin
				len_n = hdr_len;
				fbl_n = fbl_dec;
				if (!field_more) begin
					pbl_n   = leaf_nz ? hdr_len : '0;
					phase_n = leaf_nz ? tsd_pkg::PH_PAYLOAD : tsd_pkg::PH_TYPE;
				end
			end
			tsd_pkg::PH_PAYLOAD: begin
				pbl_n = pbl_dec;
				if (!pay_more) begin
					phase_n = tsd_pkg::PH_TYPE;
				end
			end
			default: begin
				phase_n = tsd_pkg::PH_TYPE;
			end
		endcase
		// truncated message drops back to a fresh element
		if (fail) begin
			phase_n = tsd_pkg::PH_TYPE;
			fbl_n   = 2'd0;
			pbl_n   = '0;
		end
	end

	// result of this byte
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (fail) begin
			res_valid = 1'b1;
			res.kind  = tsd_pkg::KIND_ERROR;
			res.err   = err_hdr ? tsd_pkg::ERR_HEADER : tsd_pkg::ERR_PAYLOAD;
			res.done  = 1'b1;
		end else if (hdr_complete) begin
			res_valid = 1'b1;
			res.kind  = tsd_pkg::KIND_HEADER;
			res.etype = saved_q[7:6];
			res.id    = (phase_q == tsd_pkg::PH_ID) ? id_shift : id_q;
			res.len   = hdr_len;
			res.last  = !leaf_nz;
			res.done  = eom;
		end else if (phase_q == tsd_pkg::PH_PAYLOAD) begin
			res_valid = 1'b1;
			res.kind  = tsd_pkg::KIND_BYTE;
			res.pbyte = in_byte;
			res.last  = !pay_more;
			res.done  = eom;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsd_pkg::PH_TYPE;
			saved_q <= '0;
			id_q    <= '0;
			len_q   <= '0;
			fbl_q   <= '0;
			pbl_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			saved_q <= saved_n;
			id_q    <= id_n;
			len_q   <= len_n;
			fbl_q   <= fbl_n;
			pbl_q   <= pbl_n;
		end
	end

	`TSD_ASSERT(a_fail_restarts, clk, arst_n, (step && fail) |=> (phase_q == tsd_pkg::PH_TYPE), "error did not return parser to type byte")
	`TSD_NEVER(a_payload_count, clk, arst_n, (phase_q == tsd_pkg::PH_PAYLOAD) && (pbl_q == '0), "payload phase with no bytes left")
	`TSD_NEVER(a_field_count, clk, arst_n, ((phase_q == tsd_pkg::PH_ID) || (phase_q == tsd_pkg::PH_LEN)) && (fbl_q == 2'd0), "header field phase with no bytes left")

endmodule

@@ design/tsd_out_reg.sv @@
// result register towards the master side
module tsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             in_valid,
	input  tsd_pkg::result_t in_res,
	output logic             valid_q,
	output tsd_pkg::result_t res_q
);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

@@ design/tlv_stream_deframer_top.sv @@
// top level of the byte-serial lwm2m tlv stream deframer
//
// Slave side takes one encoded message byte per request: s_tdata carries the
// byte, s_tlast marks the final byte of a message. Master side gives one
// result per request: header complete, payload byte or error, kind in
// m_tuser, message close in m_tlast. Container payloads are parsed as child
// elements; type, id and length bytes give no result until the header ends.
// Throughput is one byte per cycle unless a stalled receiver holds the
// result register: the parser state update is one short decode between the
// input register and the result register, which registers the result of
// each byte that gives one and raises m_tvalid.
// A stalled receiver holds the result register; one more byte waits in the
// input register, then s_tready falls until the result is taken.
// On a truncated message an error result closes it; earlier results of that
// message are to be discarded by the receiver. Reset clears both valid
// flags and returns the parser to expecting a type byte.
module tlv_stream_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // element_type[1:0], element_id[17:2],
	                               // payload_length[41:18], payload_byte[49:42],
	                               // last_of_element[50], error_code[52:51], zero
	output logic [1:0]  m_tuser,   // result_kind[1:0]
	output logic        m_tlast    // message_done
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eom_s1;
	logic             advance;
	logic             step;
	logic             res_valid;
	tsd_pkg::result_t res;
	tsd_pkg::result_t res_q;

	// handshake between the stages
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	tsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_tready),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_eom   (s_tlast),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.eom_s1   (eom_s1)
	);

	tsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.eom       (eom_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tsd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.in_valid (step && res_valid),
		.in_res   (res),
		.valid_q  (m_tvalid),
		.res_q    (res_q)
	);

	// pack the result fields
	assign m_tdata = {3'b000, res_q.err, res_q.last, res_q.pbyte, res_q.len, res_q.id,
		res_q.etype};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.done;

endmodule

@@ verif/tlv_stream_deframer_top_tb.sv @@
// self-checking testbench for the tlv stream deframer: message generator, driver and scoreboard
`timescale 1ns / 1ps

module tlv_stream_deframer_top_tb;

	// element types carried in bits 7-6 of a type byte
	localparam logic [1:0] ET_OBJ_INST  = 2'd0;
	localparam logic [1:0] ET_RES_INST  = 2'd1;
	localparam logic [1:0] ET_MULTI_RES = 2'd2;
	localparam logic [1:0] ET_RES_VALUE = 2'd3;

	localparam int unsigned RANDOM_BYTES   = 500;
	localparam int unsigned TAIL_CYCLES    = 10;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	// expected results of accepted bytes, oldest first
	class tlv_result_board;
		localparam int unsigned MAX_PRINTS = 40;
		tsd_pkg::result_t pending[$];
		int unsigned      errors = 0;

		function void note(tsd_pkg::result_t r);
			pending.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (errors < MAX_PRINTS)
				$display("%0t mismatch on %s: got %0h want %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check(tsd_pkg::result_t got, logic [2:0] pad);
			tsd_pkg::result_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending", 32'(got.kind), 32'd0);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				report("result_kind", 32'(got.kind), 32'(want.kind));
			if (got.etype !== want.etype)
				report("element_type", 32'(got.etype), 32'(want.etype));
			if (got.id !== want.id)
				report("element_id", 32'(got.id), 32'(want.id));
			if (got.len !== want.len)
				report("payload_length", 32'(got.len), 32'(want.len));
			if (got.pbyte !== want.pbyte)
				report("payload_byte", 32'(got.pbyte), 32'(want.pbyte));
			if (got.last !== want.last)
				report("last_of_element", 32'(got.last), 32'(want.last));
			if (got.err !== want.err)
				report("error_code", 32'(got.err), 32'(want.err));
			if (got.done !== want.done)
				report("message_done", 32'(got.done), 32'(want.done));
			if (pad !== 3'd0)
				report("tdata padding", 32'(pad), 32'd0);
		endtask

		task check_drained();
			if (pending.size() != 0)
				report("results never given", 32'(pending.size()), 32'd0);
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	tlv_result_board  board = new();
	int unsigned      send_idle_pct  = 0;
	int unsigned      recv_stall_pct = 0;
	int unsigned      quiet_cycles   = 0;
	logic [7:0]       msg[$];
	logic [8:0]       byte_stream[$];   // {last, byte}
	tsd_pkg::result_t seen;

	// parser state mirrored by the predictor
	tsd_pkg::phase_t ph         = tsd_pkg::PH_TYPE;
	logic [7:0]      type_byte  = 8'd0;
	logic [15:0]     id_acc     = 16'd0;
	logic [23:0]     len_acc    = 24'd0;
	logic [1:0]      field_left = 2'd0;
	logic [23:0]     pay_left   = 24'd0;

	tlv_stream_deframer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// truncation: parser back to expecting a type byte
	function automatic tsd_pkg::result_t error_result(logic [1:0] code);
		tsd_pkg::result_t r;
		r = '0;
		r.kind = tsd_pkg::KIND_ERROR;
		r.err = code;
		r.done = 1'b1;
		ph = tsd_pkg::PH_TYPE;
		field_left = 2'd0;
		pay_left = 24'd0;
		return r;
	endfunction

	// header just completed: leaves with a payload go on to payload bytes
	function automatic tsd_pkg::result_t header_result(logic eom);
		tsd_pkg::result_t r;
		logic [1:0]       et;
		logic             leaf;
		et = type_byte[7:6];
		leaf = (et == ET_RES_INST) || (et == ET_RES_VALUE);
		field_left = 2'd0;
		r = '0;
		r.kind = tsd_pkg::KIND_HEADER;
		r.etype = et;
		r.id = id_acc;
		r.len = len_acc;
		if (leaf && len_acc != 24'd0) begin
			if (eom)
				return error_result(tsd_pkg::ERR_PAYLOAD);
			ph = tsd_pkg::PH_PAYLOAD;
			pay_left = len_acc;
			return r;
		end
		ph = tsd_pkg::PH_TYPE;
		pay_left = 24'd0;
		r.last = 1'b1;
		r.done = eom;
		return r;
	endfunction

	// one accepted byte; returns 1 when it causes a result
	function automatic bit decode_byte(input logic [7:0] b, input logic eom,
		output tsd_pkg::result_t r);
		r = '0;
		case (ph)
			tsd_pkg::PH_ID: begin
				id_acc = {id_acc[7:0], b};
				field_left = field_left - 2'd1;
				if (field_left != 2'd0) begin
					if (eom) begin
						r = error_result(tsd_pkg::ERR_HEADER);
						return 1'b1;
					end
					return 1'b0;
				end
				field_left = type_byte[4:3];
				if (field_left == 2'd0) begin
					len_acc = {21'd0, type_byte[2:0]};
					r = header_result(eom);
					return 1'b1;
				end
				if (eom) begin
					r = error_result(tsd_pkg::ERR_HEADER);
					return 1'b1;
				end
				ph = tsd_pkg::PH_LEN;
				return 1'b0;
			end
			tsd_pkg::PH_LEN: begin
				len_acc = {len_acc[15:0], b};
				field_left = field_left - 2'd1;
				if (field_left != 2'd0) begin
					if (eom) begin
						r = error_result(tsd_pkg::ERR_HEADER);
						return 1'b1;
					end
					return 1'b0;
				end
				r = header_result(eom);
				return 1'b1;
			end
			tsd_pkg::PH_PAYLOAD: begin
				pay_left = pay_left - 24'd1;
				if (pay_left != 24'd0) begin
					if (eom) begin
						r = error_result(tsd_pkg::ERR_PAYLOAD);
						return 1'b1;
					end
					r.kind = tsd_pkg::KIND_BYTE;
					r.pbyte = b;
					return 1'b1;
				end
				ph = tsd_pkg::PH_TYPE;
				r.kind = tsd_pkg::KIND_BYTE;
				r.pbyte = b;
				r.last = 1'b1;
				r.done = eom;
				return 1'b1;
			end
			default: begin
				type_byte = b;
				id_acc = 16'd0;
				len_acc = 24'd0;
				pay_left = 24'd0;
				field_left = b[5] ? 2'd2 : 2'd1;
				ph = tsd_pkg::PH_ID;
				if (eom) begin
					r = error_result(tsd_pkg::ERR_HEADER);
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	// well-formed element with random type, id width, length form and content
	function automatic void add_element();
		logic [1:0]  et;
		logic [1:0]  form;
		logic        wide;
		logic [2:0]  inl;
		int unsigned len;
		int unsigned i;
		et = 2'($urandom_range(3));
		wide = 1'($urandom_range(1));
		if (et == ET_RES_INST || et == ET_RES_VALUE) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
			form = (len <= 7 && $urandom_range(1) == 1) ? 2'd0 : 2'($urandom_range(1, 3));
		end else begin
			// container length is never consumed, so any value goes
			form = 2'($urandom_range(3));
			len = (form == 2'd0) ? $urandom_range(7) : ($urandom & ((32'd1 << (8 * form)) - 1));
		end
		inl = (form == 2'd0) ? 3'(len) : 3'($urandom_range(7));
		msg.push_back({et, wide, form, inl});
		if (wide)
			msg.push_back(8'($urandom));
		msg.push_back(8'($urandom));
		for (i = 32'(form); i > 0; i--)
			msg.push_back(8'(len >> (8 * (i - 1))));
		if (et == ET_RES_INST || et == ET_RES_VALUE)
			repeat (len) msg.push_back(8'($urandom));
	endfunction

	// move the first keep bytes of the message to the stream, last one flagged
	function automatic void close_message(int unsigned keep);
		int unsigned i;
		for (i = 0; i < keep; i++)
			byte_stream.push_back({(i == keep - 1), msg[i]});
		msg.delete();
	endfunction

	// one request on the slave side, with random idle cycles ahead of it
	task automatic send_byte(logic [8:0] item);
		tsd_pkg::result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= item[7:0];
		s_tlast <= item[8];
		do @(posedge clk); while (s_tready !== 1'b1);
		if (decode_byte(item[7:0], item[8], r))
			board.note(r);
	endtask

	task automatic send_stream();
		while (byte_stream.size() != 0)
			send_byte(byte_stream.pop_front());
	endtask

	// result side: check each accepted request, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			seen.kind = m_tuser;
			seen.etype = m_tdata[1:0];
			seen.id = m_tdata[17:2];
			seen.len = m_tdata[41:18];
			seen.pbyte = m_tdata[49:42];
			seen.last = m_tdata[50];
			seen.err = m_tdata[52:51];
			seen.done = m_tlast;
			board.check(seen, m_tdata[55:53]);
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles without any request accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned p;
		int unsigned sent;
		int unsigned pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 47;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 47;
				end
				default: begin
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
			endcase
			if (p == 0) begin
				// all-ones header, 16-bit id and 24-bit length, two payload bytes
				msg = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55};
				close_message(msg.size());
				// empty container closing the message
				msg = '{8'h00, 8'h00};
				close_message(msg.size());
				// message ends on the type byte
				msg = '{8'h28};
				close_message(msg.size());
				// message ends inside a leaf payload
				msg = '{8'hC2, 8'h01, 8'h11};
				close_message(msg.size());
				// header completes on the final byte with a payload still owed
				msg = '{8'h47, 8'h09};
				close_message(msg.size());
				// container with nonzero length closing the message
				msg = '{8'h88, 8'h05, 8'hFF};
				close_message(msg.size());
				// final leaf with an empty payload
				msg = '{8'hC0, 8'h10};
				close_message(msg.size());
				send_stream();
			end
			// mostly well-formed messages, some cut short, some plain noise
			sent = 0;
			while (sent < RANDOM_BYTES / 4) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					repeat ($urandom_range(1, 4)) add_element();
					close_message(msg.size());
				end else if (pick < 85) begin
					repeat ($urandom_range(1, 3)) add_element();
					close_message($urandom_range(1, msg.size()));
				end else begin
					repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
					close_message(msg.size());
				end
				sent += byte_stream.size();
				send_stream();
			end
			// sender holds off until every result of this phase is in
			s_tvalid <= 1'b0;
			while (board.pending.size() != 0)
				@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		board.check_drained();
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
